// ===== rtl/ttpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ttpc_pkg
// Shared types and constants of the two-point touch calibration core.
// ----------------------------------------------------------------------------
package ttpc_pkg;

  localparam int unsigned FieldW       = 16;
  localparam int unsigned RawW         = 12;
  localparam int unsigned ScrW         = 8;
  localparam int unsigned FracBits     = 8;
  localparam int unsigned OffShift     = 7;

  // divider: magnitude of (raw diff << 8) over magnitude of screen diff
  localparam int unsigned QuotW        = RawW + FracBits;
  localparam int unsigned RemW         = ScrW;
  localparam int unsigned BitsPerStage = 4;
  localparam int unsigned DivStages    = QuotW / BitsPerStage;

  localparam int unsigned SumRawW      = RawW + 1;
  localparam int unsigned SumScrW      = ScrW + 1;
  localparam int unsigned ProdW        = FieldW + SumScrW + 1;
  localparam int unsigned AccW         = ProdW + 1;

  // input register, divider stages, step, product, offset
  localparam int unsigned AxisLatency  = DivStages + 4;

  typedef logic [FieldW-1:0] field_t;
  typedef logic [QuotW-1:0]  quot_t;

  localparam field_t RawLimit     = field_t'(16'h1000);
  localparam field_t ScreenXLimit = field_t'(16'h0100);
  localparam field_t ScreenYLimit = field_t'(16'h00c0);
  localparam quot_t  StepMaxMag   = quot_t'(32'h0000_7fff);
  localparam quot_t  StepMinMag   = quot_t'(32'h0000_8000);

  typedef struct packed {
    field_t raw_x_a;
    field_t raw_y_a;
    field_t screen_x_a;
    field_t screen_y_a;
    field_t raw_x_b;
    field_t raw_y_b;
    field_t screen_x_b;
    field_t screen_y_b;
  } in_t;

  typedef struct packed {
    logic               failed;
    logic signed [15:0] slope_x;
    logic signed [15:0] offset_x;
    logic signed [15:0] slope_y;
    logic signed [15:0] offset_y;
  } out_t;

  typedef struct packed {
    logic               ovf;
    logic signed [15:0] slope;
    logic signed [15:0] offset;
  } axis_res_t;

endpackage

// ===== rtl/touch_two_point_calibration_core.sv =====
// ----------------------------------------------------------------------------
// touch_two_point_calibration_core
// Per-axis slope and offset from two touch calibration points.
// ----------------------------------------------------------------------------
// A new point pair is taken in every clock cycle (busy never rises) and its
// result appears on result_o, marked by done_o for one cycle. The pipeline
// is an input register and the slope divider, which resolves four quotient
// bits per stage over five stages, followed by one stage each for the signed
// step, the multiply and the offset.
// Results cannot be held off; the receiver must take each one when it shows.
// ----------------------------------------------------------------------------
module touch_two_point_calibration_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ttpc_pkg::in_t  in_i,
  output logic           done_o,
  output ttpc_pkg::out_t result_o
);

  localparam int unsigned Lat = ttpc_pkg::AxisLatency;

  logic                accept;
  logic                bad_in;
  ttpc_pkg::axis_res_t res_x;
  ttpc_pkg::axis_res_t res_y;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_comb begin
    bad_in = (in_i.raw_x_a >= ttpc_pkg::RawLimit) || (in_i.raw_y_a >= ttpc_pkg::RawLimit)
          || (in_i.raw_x_b >= ttpc_pkg::RawLimit) || (in_i.raw_y_b >= ttpc_pkg::RawLimit)
          || (in_i.screen_x_a >= ttpc_pkg::ScreenXLimit)
          || (in_i.screen_x_b >= ttpc_pkg::ScreenXLimit)
          || (in_i.screen_y_a >= ttpc_pkg::ScreenYLimit)
          || (in_i.screen_y_b >= ttpc_pkg::ScreenYLimit)
          || (in_i.screen_x_a == in_i.screen_x_b) || (in_i.screen_y_a == in_i.screen_y_b)
          || (in_i.raw_x_a == in_i.raw_x_b) || (in_i.raw_y_a == in_i.raw_y_b);
  end

  ttpc_axis u_axis_x (
    .clk_i   (clk_i),
    .raw_a_i (in_i.raw_x_a[ttpc_pkg::RawW-1:0]),
    .raw_b_i (in_i.raw_x_b[ttpc_pkg::RawW-1:0]),
    .scr_a_i (in_i.screen_x_a[ttpc_pkg::ScrW-1:0]),
    .scr_b_i (in_i.screen_x_b[ttpc_pkg::ScrW-1:0]),
    .res_o   (res_x)
  );

  ttpc_axis u_axis_y (
    .clk_i   (clk_i),
    .raw_a_i (in_i.raw_y_a[ttpc_pkg::RawW-1:0]),
    .raw_b_i (in_i.raw_y_b[ttpc_pkg::RawW-1:0]),
    .scr_a_i (in_i.screen_y_a[ttpc_pkg::ScrW-1:0]),
    .scr_b_i (in_i.screen_y_b[ttpc_pkg::ScrW-1:0]),
    .res_o   (res_y)
  );

  // item valid and input rejection travel beside the axis pipelines
  logic vld_q  [Lat];
  logic fail_q [Lat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int i = 1; i < Lat; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fail_q[0] <= bad_in;
    for (int i = 1; i < Lat; i++) begin
      fail_q[i] <= fail_q[i-1];
    end
  end

  logic failed;

  assign failed = fail_q[Lat-1] | res_x.ovf | res_y.ovf;
  assign done_o = vld_q[Lat-1];

  always_comb begin
    result_o.failed   = failed;
    result_o.slope_x  = failed ? '0 : res_x.slope;
    result_o.offset_x = failed ? '0 : res_x.offset;
    result_o.slope_y  = failed ? '0 : res_y.slope;
    result_o.offset_y = failed ? '0 : res_y.offset;
  end

  // every result comes from a started item
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, Lat))
    else $error("result without a started item");

  a_pass_distinct_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.failed) |-> $past(in_i.screen_x_a != in_i.screen_x_b, Lat))
    else $error("passed with coinciding screen x");

  a_pass_raw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.failed) |->
      $past((in_i.raw_y_a < ttpc_pkg::RawLimit) && (in_i.raw_y_b < ttpc_pkg::RawLimit), Lat))
    else $error("passed with raw y out of range");

  a_fail_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.failed) |-> (result_o.slope_x == '0 && result_o.offset_x == '0
      && result_o.slope_y == '0 && result_o.offset_y == '0))
    else $error("failed result with nonzero fields");

endmodule

// ===== rtl/ttpc_axis.sv =====
// ----------------------------------------------------------------------------
// ttpc_axis
// One calibration axis: pipelined divider for the slope, then multiply and
// subtract for the offset. One item per cycle, no stall.
// ----------------------------------------------------------------------------
module ttpc_axis (
  input  logic                            clk_i,
  input  logic [ttpc_pkg::RawW-1:0]       raw_a_i,
  input  logic [ttpc_pkg::RawW-1:0]       raw_b_i,
  input  logic [ttpc_pkg::ScrW-1:0]       scr_a_i,
  input  logic [ttpc_pkg::ScrW-1:0]       scr_b_i,
  output ttpc_pkg::axis_res_t             res_o
);

  localparam int unsigned QW  = ttpc_pkg::QuotW;
  localparam int unsigned RW  = ttpc_pkg::RemW;
  localparam int unsigned NS  = ttpc_pkg::DivStages;
  localparam int unsigned BPS = ttpc_pkg::BitsPerStage;

  // input stage
  logic signed [ttpc_pkg::RawW:0]        raw_diff;
  logic signed [ttpc_pkg::ScrW:0]        scr_diff;
  logic [ttpc_pkg::RawW-1:0]             raw_mag;
  logic [ttpc_pkg::ScrW-1:0]             scr_mag;

  always_comb begin
    raw_diff = $signed({1'b0, raw_a_i}) - $signed({1'b0, raw_b_i});
    scr_diff = $signed({1'b0, scr_a_i}) - $signed({1'b0, scr_b_i});
    raw_mag  = raw_diff[ttpc_pkg::RawW] ? ttpc_pkg::RawW'(-raw_diff)
                                        : raw_diff[ttpc_pkg::RawW-1:0];
    scr_mag  = scr_diff[ttpc_pkg::ScrW] ? ttpc_pkg::ScrW'(-scr_diff)
                                        : scr_diff[ttpc_pkg::ScrW-1:0];
  end

  // divider pipeline, index 0 is the input register
  logic [RW-1:0]                   rem_q  [NS+1];
  logic [QW-1:0]                   dvd_q  [NS+1];
  logic [QW-1:0]                   quo_q  [NS+1];
  logic [RW-1:0]                   den_q  [NS+1];
  logic                            neg_q  [NS+1];
  logic [ttpc_pkg::SumRawW-1:0]    sraw_q [NS+1];
  logic [ttpc_pkg::SumScrW-1:0]    sscr_q [NS+1];

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    dvd_q[0]  <= {raw_mag, {ttpc_pkg::FracBits{1'b0}}};
    quo_q[0]  <= '0;
    den_q[0]  <= scr_mag;
    neg_q[0]  <= raw_diff[ttpc_pkg::RawW] ^ scr_diff[ttpc_pkg::ScrW];
    sraw_q[0] <= {1'b0, raw_a_i} + {1'b0, raw_b_i};
    sscr_q[0] <= {1'b0, scr_a_i} + {1'b0, scr_b_i};
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [RW-1:0] rem_d;
    logic [QW-1:0] dvd_d;
    logic [QW-1:0] quo_d;

    always_comb begin
      logic [RW:0] trial;
      logic [RW:0] sub;
      rem_d = rem_q[k];
      dvd_d = dvd_q[k];
      quo_d = quo_q[k];
      for (int j = 0; j < BPS; j++) begin
        trial = {rem_d, dvd_d[QW-1]};
        sub   = trial - {1'b0, den_q[k]};
        dvd_d = {dvd_d[QW-2:0], 1'b0};
        if (trial >= {1'b0, den_q[k]}) begin
          rem_d = sub[RW-1:0];
          quo_d = {quo_d[QW-2:0], 1'b1};
        end else begin
          rem_d = trial[RW-1:0];
          quo_d = {quo_d[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= rem_d;
      dvd_q[k+1]  <= dvd_d;
      quo_q[k+1]  <= quo_d;
      den_q[k+1]  <= den_q[k];
      neg_q[k+1]  <= neg_q[k];
      sraw_q[k+1] <= sraw_q[k];
      sscr_q[k+1] <= sscr_q[k];
    end
  end

  // signed step and range check
  logic [QW-1:0]                   quo;
  logic                            ovf_d;
  logic signed [15:0]              step_d;
  logic signed [15:0]              step_q;
  logic                            ovf_q;
  logic [ttpc_pkg::SumRawW-1:0]    sraw_s_q;
  logic [ttpc_pkg::SumScrW-1:0]    sscr_s_q;

  always_comb begin
    quo    = quo_q[NS];
    ovf_d  = neg_q[NS] ? (quo > ttpc_pkg::StepMinMag) : (quo > ttpc_pkg::StepMaxMag);
    step_d = neg_q[NS] ? 16'(-quo) : quo[15:0];
  end

  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    ovf_q    <= ovf_d;
    sraw_s_q <= sraw_q[NS];
    sscr_s_q <= sscr_q[NS];
  end

  // step times screen sum
  logic signed [ttpc_pkg::ProdW-1:0] prod_d;
  logic signed [ttpc_pkg::ProdW-1:0] prod_q;
  logic signed [15:0]                step_p_q;
  logic                              ovf_p_q;
  logic [ttpc_pkg::SumRawW-1:0]      sraw_p_q;

  assign prod_d = step_q * $signed({1'b0, sscr_s_q});

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    step_p_q <= step_q;
    ovf_p_q  <= ovf_q;
    sraw_p_q <= sraw_s_q;
  end

  // offset: floor shift is the arithmetic shift of the two's complement value
  logic signed [ttpc_pkg::AccW-1:0] acc;
  ttpc_pkg::axis_res_t              res_d;
  ttpc_pkg::axis_res_t              res_q;

  always_comb begin
    acc = $signed({{(ttpc_pkg::AccW - ttpc_pkg::SumRawW - ttpc_pkg::FracBits){1'b0}},
                   sraw_p_q, {ttpc_pkg::FracBits{1'b0}}})
        - ttpc_pkg::AccW'(prod_q);
    res_d.ovf    = ovf_p_q;
    res_d.slope  = step_p_q;
    res_d.offset = acc[ttpc_pkg::OffShift +: 16];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule
